>>> hw/rtl/adv_name_matcher_assert.svh
// ---------------------------------------------------------------------------
// adv_name_matcher assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ADV_NAME_MATCHER_ASSERT_SVH
`define ADV_NAME_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ANM_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication
`define ANM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`else

`define ANM_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ANM_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

>>> hw/rtl/anm_pkg.sv
// ---------------------------------------------------------------------------
// anm_pkg
// Shared types and constants for the advertising name matcher.
// ---------------------------------------------------------------------------
package anm_pkg;

   localparam int NAME_BYTES = 31;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 5;
   localparam int WORD_W     = 64;
   localparam int NUM_WORDS  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int REM_W      = 8;

   // AD type codes of the local name elements
   localparam logic [BYTE_W-1:0] TYPE_SHORT_NAME = 8'h08;
   localparam logic [BYTE_W-1:0] TYPE_FULL_NAME  = 8'h09;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_LEN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_WORD0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_WORD1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_WORD2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_WORD3 = 3'd4;

   // element walk phase
   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_BODY
   } phase_type;

   // configured name, byte k in slot k
   typedef logic [NUM_WORDS*8-1:0][BYTE_W-1:0] name_type;

   // one item handed to the walker
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] adv_byte;
      logic              last_byte;
   } step_type;

endpackage

>>> hw/rtl/anm_walker.sv
// ---------------------------------------------------------------------------
// anm_walker
// Walks length-type-value elements one byte per step and tracks name matches.
// ---------------------------------------------------------------------------
module anm_walker
   import anm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  step_type         step,
   input  logic [LEN_W-1:0] name_len,
   input  name_type         name,
   output logic             found
);

   phase_type         phase_ff, phase_in;
   logic [REM_W-1:0]  remaining_ff, remaining_in;
   logic              name_elem_ff, name_elem_in;
   logic [LEN_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              mismatch_ff, mismatch_in;
   logic              matched_ff, matched_in;

   logic [REM_W-1:0]  rem_dec;
   logic              is_name;

   assign rem_dec = remaining_ff - REM_W'(1);
   assign is_name = (step.adv_byte == TYPE_SHORT_NAME) ||
                    (step.adv_byte == TYPE_FULL_NAME);

   // next state for one payload byte
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      name_elem_in = name_elem_ff;
      cmp_idx_in   = cmp_idx_ff;
      mismatch_in  = mismatch_ff;
      matched_in   = matched_ff;
      unique case (phase_ff)
         PH_LEN: begin
            // zero-length element is skipped
            if (step.adv_byte != '0) begin
               remaining_in = step.adv_byte;
               phase_in     = PH_TYPE;
            end
         end
         PH_TYPE: begin
            remaining_in = rem_dec;
            name_elem_in = is_name;
            cmp_idx_in   = '0;
            mismatch_in  = 1'b0;
            if (is_name && (name_len == '0)) begin
               matched_in = 1'b1;
            end
            phase_in = (rem_dec == '0) ? PH_LEN : PH_BODY;
         end
         PH_BODY: begin
            if (name_elem_ff && !mismatch_ff && (cmp_idx_ff < name_len)) begin
               mismatch_in = (step.adv_byte != name[cmp_idx_ff]);
               cmp_idx_in  = cmp_idx_ff + LEN_W'(1);
               if (!mismatch_in && (cmp_idx_in == name_len)) begin
                  matched_in = 1'b1;
               end
            end
            remaining_in = rem_dec;
            if (rem_dec == '0) begin
               // element ended before the whole name was seen
               if (name_elem_ff && (cmp_idx_in < name_len)) begin
                  mismatch_in = 1'b1;
               end
               phase_in = PH_LEN;
            end
         end
         default: begin
            phase_in = PH_LEN;
         end
      endcase
   end

   // verdict includes the current byte
   assign found = matched_in;

   // state registers, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last_byte)) begin
         phase_ff     <= PH_LEN;
         remaining_ff <= '0;
         name_elem_ff <= 1'b0;
         cmp_idx_ff   <= '0;
         mismatch_ff  <= 1'b0;
         matched_ff   <= 1'b0;
      end else if (step.valid) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         name_elem_ff <= name_elem_in;
         cmp_idx_ff   <= cmp_idx_in;
         mismatch_ff  <= mismatch_in;
         matched_ff   <= matched_in;
      end
   end

endmodule

>>> hw/rtl/adv_name_matcher.sv
// The final byte passes the input register and then the result register to the found result.
// Throughput: one item per cycle; one walker step per cycle on registered input.
// An item with the final-byte flag blocks only while a result waits under stall.
// Reset (synchronous, active high) clears the walk state, empties both
// registers and clears all configuration registers to zero.
// ---------------------------------------------------------------------------
// adv_name_matcher
// Scans advertising payload bytes for a local name element with the set name.
// ---------------------------------------------------------------------------
`include "adv_name_matcher_assert.svh"

module adv_name_matcher
   import anm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_adv_byte,
   input  logic                 req_last_byte,
   // results
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [LEN_W-1:0]  name_len_ff;
   logic [WORD_W-1:0] name_word_ff [NUM_WORDS];
   name_type          name;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   logic              rsp_found_ff;

   logic              process;
   logic              req_take;
   logic              rsp_take;
   logic              walker_found;
   step_type          step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff <= '0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            name_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NAME_LEN:   name_len_ff     <= csr_wdata[LEN_W-1:0];
            CSR_NAME_WORD0: name_word_ff[0] <= csr_wdata;
            CSR_NAME_WORD1: name_word_ff[1] <= csr_wdata;
            CSR_NAME_WORD2: name_word_ff[2] <= csr_wdata;
            CSR_NAME_WORD3: name_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign name = {name_word_ff[3], name_word_ff[2], name_word_ff[1], name_word_ff[0]};

   // handshake: final byte waits only for a free result slot
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign process   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take || process) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_adv_byte;
         in_last_ff <= req_last_byte;
      end
   end

   assign step = '{valid: process, adv_byte: in_byte_ff, last_byte: in_last_ff};

   anm_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .name_len (name_len_ff),
      .name     (name),
      .found    (walker_found)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && in_last_ff) begin
         rsp_found_ff <= walker_found;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   // checks
   `ANM_ASSERT_NEXT(a_last_gives_rsp, clock, reset, process && in_last_ff, rsp_valid_ff)
   `ANM_ASSERT_IMPLIES(a_empty_no_stall, clock, reset, !in_valid_ff, !req_stall)
   `ANM_ASSERT_IMPLIES(a_no_overwrite, clock, reset, process && in_last_ff && rsp_valid_ff, rsp_take)

endmodule

>>> tb/adv_name_matcher_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adv_name_matcher_tb
// Feeds advertising payload bytes through the name matcher and compares every
// found flag with a local walk of the length-type-value elements. A short
// directed run covers the element corner cases, then random packets run under
// several name settings, with bursty input and a patterned result stall.
// ---------------------------------------------------------------------------
module adv_name_matcher_tb;
   import anm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 44;
   localparam int DRAIN_CYCLES   = 4;
   localparam int END_CYCLES     = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } adv_item_type;

   // block ports
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_adv_byte  = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic                 rsp_found;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_NAME_LEN;
   logic [WORD_W-1:0]    csr_wdata     = '0;

   // stimulus and expected results
   adv_item_type      pending_items[$];
   logic [BYTE_W-1:0] pkt[$];
   logic              predicted_found[$];
   int                phase_items;
   int                error_count = 0;

   // shadow of the name registers
   logic [LEN_W-1:0]  cfg_name_len = '0;
   logic [WORD_W-1:0] cfg_word[NUM_WORDS] = '{default: '0};

   // element walk state
   phase_type         walk_phase = PH_LEN;
   logic [REM_W-1:0]  walk_left  = '0;
   logic              in_name    = 1'b0;
   int                cmp_idx    = 0;
   logic              cmp_bad    = 1'b0;
   logic              pkt_match  = 1'b0;

   // driver and receiver pacing
   adv_item_type      next_item;
   int                burst_left = 1;
   int                gap_left   = 0;
   int                stall_tick = 0;
   int                stall_mode = 0;

   adv_name_matcher dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_adv_byte  (req_adv_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [BYTE_W-1:0] cfg_name_byte(input int k);
      return cfg_word[k / 8][(k % 8) * 8 +: 8];
   endfunction

   task automatic report_error(input string what);
      $display("[%0t] ERROR: %s", $time, what);
      error_count++;
   endtask

   // advance the element walk by one accepted byte
   task automatic scan_adv_byte(input logic [BYTE_W-1:0] b, input logic last);
      int n;
      n = (int'(cfg_name_len) > NAME_BYTES) ? NAME_BYTES : int'(cfg_name_len);
      case (walk_phase)
         PH_LEN: begin
            // zero length elements are skipped
            if (b != 8'h00) begin
               walk_left  = b;
               walk_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            walk_left = walk_left - 1'b1;
            in_name   = (b == TYPE_SHORT_NAME) || (b == TYPE_FULL_NAME);
            cmp_idx   = 0;
            cmp_bad   = 1'b0;
            if (in_name && n == 0)
               pkt_match = 1'b1;
            walk_phase = (walk_left == '0) ? PH_LEN : PH_BODY;
         end
         default: begin
            if (in_name && !cmp_bad && cmp_idx < n) begin
               if (b != cfg_name_byte(cmp_idx))
                  cmp_bad = 1'b1;
               cmp_idx++;
               if (!cmp_bad && cmp_idx == n)
                  pkt_match = 1'b1;
            end
            walk_left = walk_left - 1'b1;
            if (walk_left == '0) begin
               // element ended before the whole name was seen
               if (in_name && cmp_idx < n)
                  cmp_bad = 1'b1;
               walk_phase = PH_LEN;
            end
         end
      endcase
      // final byte: one flag per packet, then start over
      if (last) begin
         predicted_found.push_back(pkt_match);
         walk_phase = PH_LEN;
         walk_left  = '0;
         in_name    = 1'b0;
         cmp_idx    = 0;
         cmp_bad    = 1'b0;
         pkt_match  = 1'b0;
      end
   endtask

   // move the built packet into the item queue, flagging its final byte
   task automatic queue_packet();
      adv_item_type it;
      for (int i = 0; i < pkt.size(); i++) begin
         it.data = pkt[i];
         it.last = (i == pkt.size() - 1);
         pending_items.push_back(it);
         phase_items++;
      end
      pkt.delete();
   endtask

   // one random packet, mostly well formed name elements
   task automatic build_random_packet();
      logic [BYTE_W-1:0] body[$];
      logic [BYTE_W-1:0] typ;
      int kind, style, nelem, n, cut, bad;
      kind  = $urandom_range(0, 9);
      n     = int'(cfg_name_len);
      if (kind == 0) begin
         // noise
         repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      end else begin
         nelem = $urandom_range(1, 4);
         repeat (nelem) begin
            if ($urandom_range(0, 7) == 0)
               pkt.push_back(8'h00);
            if ($urandom_range(0, 2) != 0)
               typ = $urandom_range(0, 1) ? TYPE_SHORT_NAME : TYPE_FULL_NAME;
            else
               typ = 8'($urandom);
            body.delete();
            style = $urandom_range(0, 3);
            case (style)
               0: begin
                  // full name, maybe with trailing bytes
                  for (int k = 0; k < n; k++) body.push_back(cfg_name_byte(k));
                  repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
               end
               1: begin
                  // one byte of the name corrupted
                  for (int k = 0; k < n; k++) body.push_back(cfg_name_byte(k));
                  if (n > 0) begin
                     bad = $urandom_range(0, n - 1);
                     body[bad] = body[bad] ^ 8'($urandom_range(1, 255));
                  end
               end
               2: begin
                  // element shorter than the name
                  cut = (n > 0) ? $urandom_range(0, n - 1) : 0;
                  for (int k = 0; k < cut; k++) body.push_back(cfg_name_byte(k));
               end
               default: begin
                  repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
               end
            endcase
            pkt.push_back(8'(body.size() + 1));
            pkt.push_back(typ);
            foreach (body[k]) pkt.push_back(body[k]);
         end
         // packet cut off inside an element
         if (kind == 1 && pkt.size() > 1) begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
         end
      end
      queue_packet();
   endtask

   // register write, driven at the current edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_NAME_LEN)
         cfg_name_len = data[LEN_W-1:0];
      else
         cfg_word[idx - CSR_NAME_WORD0] = data;
   endtask

   // wait until every item is taken and every flag is back, then let it settle
   task automatic wait_idle(input int settle);
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || predicted_found.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            scan_adv_byte(req_adv_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_item = pending_items.pop_front();
               req_valid     <= 1'b1;
               req_adv_byte  <= next_item.data;
               req_last_byte <= next_item.last;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
                  gap_left   = $urandom_range(0, 6);
               end
            end
         end
      end
   end

   // monitor: check each found flag, stall on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_found.size() == 0)
               report_error($sformatf("unexpected result, found=%0b", rsp_found));
            else if (rsp_found !== predicted_found[0])
               report_error($sformatf("found=%0b, predicted %0b",
                                      rsp_found, predicted_found[0]));
            if (predicted_found.size() != 0)
               void'(predicted_found.pop_front());
         end
         stall_tick++;
         if (stall_tick % 50 == 0)
            stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= (stall_tick % 7) < 4;
         endcase
      end
   end

   // watchdog: too long without any handshake or write
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   // stimulus sequence
   initial begin
      logic [WORD_W-1:0] word;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty name after reset: zero length element, two name elements, 0xFF byte
      pkt = '{8'h00, 8'h02, 8'h09, 8'hFF, 8'h01, 8'h08};
      queue_packet();
      pkt = '{8'h00};
      queue_packet();
      wait_idle(DRAIN_CYCLES);

      // three byte name "ABC", junk in the unused bytes
      word = {$urandom, $urandom};
      word[23:0] = 24'h434241;
      write_reg(CSR_NAME_WORD0, word);
      write_reg(CSR_NAME_LEN, WORD_W'(3));
      csr_we <= 1'b0;
      // element too short for the name, then a short name match
      pkt = '{8'h03, 8'h09, 8'h41, 8'h42, 8'h04, 8'h08, 8'h41, 8'h42, 8'h43};
      queue_packet();
      // packet ends inside the name
      pkt = '{8'h05, 8'h09, 8'h41, 8'h42};
      queue_packet();
      // middle byte differs
      pkt = '{8'h04, 8'h09, 8'h41, 8'h58, 8'h43};
      queue_packet();
      wait_idle(DRAIN_CYCLES);

      // random phases: length 0, 31, 1, then random
      for (int p = 0; p < 8; p++) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            if (p == 1)
               word = '1;
            else if (p == 2)
               word = '0;
            else
               word = {$urandom, $urandom};
            write_reg(CSR_NAME_WORD0 + CSR_IDX_W'(w), word);
         end
         case (p)
            0:       word = WORD_W'(0);
            1:       word = WORD_W'(31);
            2:       word = WORD_W'(1);
            default: word = {$urandom, $urandom};
         endcase
         write_reg(CSR_NAME_LEN, word);
         csr_we <= 1'b0;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS)
            build_random_packet();
         wait_idle((p == 7) ? END_CYCLES : DRAIN_CYCLES);
      end

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
